// ===== src/hfr_pkg.sv =====
// ----------------------------------------------------------------------------
// hfr_pkg
// Shared types and constants of the hex frame request receiver: character
// codes, field sizes, event codes and the classified request that travels
// from the front end through the queue to the frame engine.
// ----------------------------------------------------------------------------
package hfr_pkg;

   localparam int HEX_DIGITS    = 8;
   localparam int DIGEST_DIGITS = 8;
   localparam int LAST_POS      = 2 * HEX_DIGITS + 3;
   localparam int POS_W         = $clog2(LAST_POS + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_LA      = 8'h61;
   localparam logic [7:0] CHAR_LF      = 8'h66;
   localparam logic [7:0] CHAR_UA      = 8'h41;
   localparam logic [7:0] CHAR_UF      = 8'h46;

   localparam logic [2:0] EV_HEADER  = 3'd0;
   localparam logic [2:0] EV_PAYLOAD = 3'd1;
   localparam logic [2:0] EV_OK      = 3'd2;
   localparam logic [2:0] EV_FORMAT  = 3'd3;
   localparam logic [2:0] EV_CRC     = 3'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [3:0] nibble;
      logic       nib_ok;
      logic       is_comma;
      logic       is_hash;
      logic       is_pct;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// ===== src/hfr_classify.sv =====
// ----------------------------------------------------------------------------
// hfr_classify
// Front end: decodes each incoming byte into its hex nibble and delimiter
// flags so the frame engine sees a ready-made classification.
// ----------------------------------------------------------------------------
module hfr_classify (
   input  logic [7:0]         rx_byte,
   output hfr_pkg::entry_type entry
);

   always_comb begin
      entry          = '0;
      entry.rx_byte  = rx_byte;
      entry.is_comma = (rx_byte == hfr_pkg::CHAR_COMMA);
      entry.is_hash  = (rx_byte == hfr_pkg::CHAR_HASH);
      entry.is_pct   = (rx_byte == hfr_pkg::CHAR_PERCENT);
      if (rx_byte >= hfr_pkg::CHAR_0 && rx_byte <= hfr_pkg::CHAR_9) begin
         entry.nib_ok = 1'b1;
         entry.nibble = 4'(rx_byte - hfr_pkg::CHAR_0);
      end else if (rx_byte >= hfr_pkg::CHAR_LA && rx_byte <= hfr_pkg::CHAR_LF) begin
         entry.nib_ok = 1'b1;
         entry.nibble = 4'(rx_byte - hfr_pkg::CHAR_LA + 8'd10);
      end else if (rx_byte >= hfr_pkg::CHAR_UA && rx_byte <= hfr_pkg::CHAR_UF) begin
         entry.nib_ok = 1'b1;
         entry.nibble = 4'(rx_byte - hfr_pkg::CHAR_UA + 8'd10);
      end
   end

endmodule

// ===== src/hfr_queue.sv =====
// ----------------------------------------------------------------------------
// hfr_queue
// Short request queue between the front end and the frame engine. Full is
// taken from the stored count only, so stall never waits on the far side.
// ----------------------------------------------------------------------------
module hfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hfr_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output hfr_pkg::head_type  head
);

   hfr_pkg::entry_type                 slot_ff [hfr_pkg::QUEUE_DEPTH];
   logic [hfr_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [hfr_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [hfr_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                               do_push, do_pop;

   assign full       = (count_ff == hfr_pkg::QCNT_W'(hfr_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/hfr_back.sv =====
// ----------------------------------------------------------------------------
// hfr_back
// Frame engine: walks hunt, header, payload and digest one request per cycle
// unless stalled, keeps the running CRC-32C, loads the event output register.
// ----------------------------------------------------------------------------
module hfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  hfr_pkg::head_type   head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_event_kind,
   output logic [7:0]          rsp_command_char,
   output logic [31:0]         rsp_argument,
   output logic [31:0]         rsp_payload_length,
   output logic                rsp_binary_payload,
   output logic [7:0]          rsp_payload_byte
);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_DIGEST  = 2'd3;

   localparam int PW = hfr_pkg::POS_W;
   localparam logic [PW-1:0] POS_COMMA1 = PW'(1);
   localparam logic [PW-1:0] POS_COMMA2 = PW'(hfr_pkg::HEX_DIGITS + 2);
   localparam logic [PW-1:0] POS_ARG_E  = PW'(hfr_pkg::HEX_DIGITS + 1);
   localparam logic [PW-1:0] POS_LEN_E  = PW'(2 * hfr_pkg::HEX_DIGITS + 2);
   localparam logic [PW-1:0] POS_LAST   = PW'(hfr_pkg::LAST_POS);
   localparam logic [PW-1:0] POS_DIG_L  = PW'(hfr_pkg::DIGEST_DIGITS - 1);
   localparam logic [31:0]   CRC_POLY   = 32'h82F63B78;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] hex_acc(input logic [31:0] acc,
                                           input hfr_pkg::entry_type e);
      return e.nib_ok ? {acc[27:0], e.nibble} : 32'hFFFF_FFFF;
   endfunction

   logic [7:0]    start_ff;
   logic [1:0]    phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   rem_ff, rem_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [31:0]   arg_ff, arg_in;
   logic [31:0]   len_ff, len_in;
   logic [31:0]   dig_ff, dig_in;
   logic [31:0]   crc_ff, crc_in;
   logic [3:0]    hi_ff, hi_in;
   logic          bin_ff, bin_in;
   logic          fok_ff, fok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    kind_ff;
   logic [7:0]    byte_ff;
   logic [7:0]    cmd_o_ff;
   logic [31:0]   arg_o_ff, len_o_ff;
   logic          bin_o_ff;

   hfr_pkg::entry_type e;
   logic          term, emit, out_free, delim_ok;
   logic [2:0]    kind;
   logic [7:0]    pbyte;
   logic [31:0]   crc_next, rem_dec;
   logic [PW-1:0] pos_inc;

   assign e        = head.entry;
   assign term     = e.is_hash | e.is_pct;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head.valid && out_free;
   assign crc_next = crc_byte(crc_ff, e.rx_byte);
   assign rem_dec  = rem_ff - 32'd1;
   assign pos_inc  = pos_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      cmd_in   = cmd_ff;
      arg_in   = arg_ff;
      len_in   = len_ff;
      dig_in   = dig_ff;
      crc_in   = crc_ff;
      hi_in    = hi_ff;
      bin_in   = bin_ff;
      fok_in   = fok_ff;
      emit     = 1'b0;
      kind     = hfr_pkg::EV_HEADER;
      pbyte    = 8'd0;
      delim_ok = 1'b0;
      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff < POS_LAST && term) begin
               phase_in = PH_HUNT;
               emit     = 1'b1;
               kind     = hfr_pkg::EV_FORMAT;
            end else begin
               crc_in = crc_next;
               pos_in = pos_inc;
               if (pos_ff == '0) begin
                  cmd_in = e.rx_byte;
               end else if (pos_ff == POS_COMMA1 || pos_ff == POS_COMMA2) begin
                  if (!e.is_comma) begin
                     fok_in = 1'b0;
                  end
               end else if (pos_ff <= POS_ARG_E) begin
                  arg_in = hex_acc(arg_ff, e);
               end else if (pos_ff <= POS_LEN_E) begin
                  len_in = hex_acc(len_ff, e);
               end else begin
                  pos_in   = pos_ff;
                  delim_ok = term;
                  emit     = 1'b1;
                  if (e.is_pct) begin
                     bin_in = 1'b1;
                  end
                  if (!(fok_ff && delim_ok)) begin
                     fok_in   = 1'b0;
                     phase_in = PH_HUNT;
                     kind     = hfr_pkg::EV_FORMAT;
                  end else begin
                     rem_in   = len_ff;
                     dig_in   = '0;
                     pos_in   = '0;
                     phase_in = (len_ff != '0) ? PH_PAYLOAD : PH_DIGEST;
                     kind     = hfr_pkg::EV_HEADER;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            crc_in = crc_next;
            if (!bin_ff && pos_ff == '0) begin
               hi_in  = e.nib_ok ? e.nibble : 4'hF;
               pos_in = PW'(1);
            end else begin
               if (bin_ff) begin
                  pbyte = e.rx_byte;
               end else begin
                  pbyte  = {hi_ff, 4'd0} + (e.nib_ok ? {4'd0, e.nibble} : 8'hFF);
                  pos_in = '0;
               end
               emit   = 1'b1;
               kind   = hfr_pkg::EV_PAYLOAD;
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_DIGEST;
                  pos_in   = '0;
                  dig_in   = '0;
               end
            end
         end
         PH_DIGEST: begin
            if (pos_ff < POS_DIG_L && term) begin
               phase_in = PH_HUNT;
               emit     = 1'b1;
               kind     = hfr_pkg::EV_CRC;
            end else begin
               dig_in = hex_acc(dig_ff, e);
               pos_in = pos_inc;
               if (pos_ff >= POS_DIG_L) begin
                  phase_in = PH_HUNT;
                  emit     = 1'b1;
                  kind     = (dig_in == ~crc_ff) ? hfr_pkg::EV_OK : hfr_pkg::EV_CRC;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (e.rx_byte == start_ff) begin
               phase_in = PH_HEADER;
               pos_in   = '0;
               rem_in   = '0;
               cmd_in   = '0;
               arg_in   = '0;
               len_in   = '0;
               dig_in   = '0;
               crc_in   = 32'hFFFF_FFFF;
               hi_in    = '0;
               bin_in   = 1'b0;
               fok_in   = 1'b1;
            end
         end
      endcase
      rsp_valid_in = pop ? emit : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         phase_ff     <= PH_HUNT;
         pos_ff       <= '0;
         rem_ff       <= '0;
         cmd_ff       <= '0;
         arg_ff       <= '0;
         len_ff       <= '0;
         dig_ff       <= '0;
         crc_ff       <= 32'hFFFF_FFFF;
         hi_ff        <= '0;
         bin_ff       <= 1'b0;
         fok_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
         if (pop) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            rem_ff   <= rem_in;
            cmd_ff   <= cmd_in;
            arg_ff   <= arg_in;
            len_ff   <= len_in;
            dig_ff   <= dig_in;
            crc_ff   <= crc_in;
            hi_ff    <= hi_in;
            bin_ff   <= bin_in;
            fok_ff   <= fok_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff  <= kind;
         byte_ff  <= pbyte;
         cmd_o_ff <= cmd_in;
         arg_o_ff <= arg_in;
         len_o_ff <= len_in;
         bin_o_ff <= bin_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_command_char   = cmd_o_ff;
   assign rsp_argument       = arg_o_ff;
   assign rsp_payload_length = len_o_ff;
   assign rsp_binary_payload = bin_o_ff;
   assign rsp_payload_byte   = byte_ff;

endmodule

// ===== src/hex_frame_request_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// hex_frame_request_receiver_unit
// Receives a hex-framed request one byte at a time and reports header,
// payload bytes and the frame's CRC-32C outcome as events.
// ----------------------------------------------------------------------------
// One request (byte) is taken per cycle while not stalled. A taken request
// enters a two-entry queue; the frame engine retires one queued request per
// cycle unless output stalls, updating the byte-wide CRC-32C and the
// header/payload/digest fields in a single step, and any event it raises is
// loaded into the output register at the edge that retires the request, so
// an event follows its request through a queue slot and the output register.
// req_stall rises only while both queue entries are occupied, which happens
// when rsp_stall holds an event waiting. A frame opens on csr_wr_data's
// stored start character; write it only while the block is idle.
module hex_frame_request_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_command_char,
   output logic [31:0] rsp_argument,
   output logic [31:0] rsp_payload_length,
   output logic        rsp_binary_payload,
   output logic [7:0]  rsp_payload_byte
);

   hfr_pkg::entry_type entry;
   hfr_pkg::head_type  head;
   logic               full, pop;

   assign req_stall = full;

   hfr_classify u_classify (
      .rx_byte (req_rx_byte),
      .entry   (entry)
   );

   hfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (entry),
      .full       (full),
      .pop        (pop),
      .head       (head)
   );

   hfr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_command_char   (rsp_command_char),
      .rsp_argument       (rsp_argument),
      .rsp_payload_length (rsp_payload_length),
      .rsp_binary_payload (rsp_binary_payload),
      .rsp_payload_byte   (rsp_payload_byte)
   );

endmodule

// ===== src/hfr_checker.sv =====
// ----------------------------------------------------------------------------
// hfr_checker
// Port-level checks of the receiver's event channel, bound to the top level.
// ----------------------------------------------------------------------------
module hfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_kind,
   input logic [7:0]  rsp_payload_byte
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("event pending after reset");

   a_event_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
                                 && $stable(rsp_payload_byte))
      else $error("stalled event changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind <= hfr_pkg::EV_CRC)
      else $error("undefined event kind");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != hfr_pkg::EV_PAYLOAD |-> rsp_payload_byte == 8'd0)
      else $error("payload byte set on a non-payload event");

   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall && !$past(reset) |-> $past(rsp_valid && rsp_stall) || $past(req_stall))
      else $error("request stall without a waiting event");

endmodule

bind hex_frame_request_receiver_unit hfr_checker u_hfr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_payload_byte (rsp_payload_byte)
);

// ===== verif/hex_frame_request_receiver_unit_tb.sv =====
// ----------------------------------------------------------------------------
// hex_frame_request_receiver_unit testbench
// Streams framed requests (start character, command, hex argument and length,
// hex or binary payload, CRC-32C digest) into the receiver, mixed with line
// noise and damaged frames, under random idle and stall on both channels.
// A byte-level decoder in the bench predicts every event; the monitor
// compares each event field by field, in order. The start character is
// rewritten between phases while the receiver is idle.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] CRC32C_POLY  = 32'h82F6_3B78;
   localparam int          SETTLE_TICKS = 8;
   localparam int          QUIET_LIMIT  = 4000;
   localparam int          PHASE_BYTES  = 120;

   typedef enum logic [1:0] {
      SCAN_HUNT, SCAN_HEADER, SCAN_PAYLOAD, SCAN_DIGEST
   } scan_phase_type;

   typedef enum int {
      FLAW_NONE, FLAW_COMMA, FLAW_DELIM, FLAW_ARG_DIGIT, FLAW_LEN_DIGIT, FLAW_HEADER_CUT,
      FLAW_PAYLOAD_DIGIT, FLAW_CRC, FLAW_DIGEST_DIGIT, FLAW_DIGEST_CUT, FLAW_DIGEST_TERM
   } frame_flaw_type;

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  cmd;
      logic [31:0] arg;
      logic [31:0] len;
      logic        raw;
      logic [7:0]  data;
   } frame_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [7:0]  rsp_command_char;
   logic [31:0] rsp_argument;
   logic [31:0] rsp_payload_length;
   logic        rsp_binary_payload;
   logic [7:0]  rsp_payload_byte;

   logic [7:0]      byte_backlog[$];
   frame_event_type events_due[$];
   logic [7:0]      frame_open_char = 8'd0;
   int              mismatch_count = 0;

   scan_phase_type  scan_phase;
   int unsigned     scan_pos;
   logic [31:0]     bytes_left, arg_acc, len_acc, digest_acc, crc_acc;
   logic [7:0]      cmd_seen, scan_open_char;
   logic [3:0]      high_nibble;
   logic            raw_mode, header_good;

   int tx_gap, tx_calm, rx_hold, rx_calm;
   int quiet_cycles = 0;

   hex_frame_request_receiver_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_command_char   (rsp_command_char),
      .rsp_argument       (rsp_argument),
      .rsp_payload_length (rsp_payload_length),
      .rsp_binary_payload (rsp_binary_payload),
      .rsp_payload_byte   (rsp_payload_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= hfr_pkg::CHAR_0 && c <= hfr_pkg::CHAR_9)
         return int'(c - hfr_pkg::CHAR_0);
      if (c >= hfr_pkg::CHAR_LA && c <= hfr_pkg::CHAR_LF)
         return int'(c - hfr_pkg::CHAR_LA) + 10;
      if (c >= hfr_pkg::CHAR_UA && c <= hfr_pkg::CHAR_UF)
         return int'(c - hfr_pkg::CHAR_UA) + 10;
      return -1;
   endfunction

   function automatic logic [31:0] shift_hex(input logic [31:0] acc, input logic [7:0] c);
      int          v;
      logic [31:0] value;
      v = hex_nibble(c);
      value = v;
      return (v < 0) ? 32'hFFFF_FFFF : ((acc << 4) | value);
   endfunction

   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      int          i;
      c = crc ^ {24'd0, b};
      for (i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("[%0t] MISMATCH %s", $time, what);
   endtask

   // ------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------
   task automatic clear_decoder();
      scan_phase = SCAN_HUNT;
      scan_pos = 0;
      bytes_left = '0;
      cmd_seen = '0;
      arg_acc = '0;
      len_acc = '0;
      digest_acc = '0;
      crc_acc = 32'hFFFF_FFFF;
      high_nibble = '0;
      raw_mode = 1'b0;
      header_good = 1'b1;
   endtask

   task automatic log_event(input logic [2:0] kind, input logic [7:0] data);
      frame_event_type ev;
      ev.kind = kind;
      ev.cmd = cmd_seen;
      ev.arg = arg_acc;
      ev.len = len_acc;
      ev.raw = raw_mode;
      ev.data = data;
      events_due.push_back(ev);
   endtask

   task automatic advance_decoder(input logic [7:0] b);
      bit         term;
      int         v;
      logic [7:0] low, data;
      term = (b == hfr_pkg::CHAR_HASH) || (b == hfr_pkg::CHAR_PERCENT);
      case (scan_phase)
         SCAN_HEADER: begin
            if (scan_pos < hfr_pkg::LAST_POS && term) begin
               scan_phase = SCAN_HUNT;
               log_event(hfr_pkg::EV_FORMAT, 8'd0);
            end else begin
               crc_acc = crc32c_byte(crc_acc, b);
               if (scan_pos == hfr_pkg::LAST_POS) begin
                  if (b == hfr_pkg::CHAR_PERCENT) raw_mode = 1'b1;
                  else if (b != hfr_pkg::CHAR_HASH) header_good = 1'b0;
                  if (!header_good) begin
                     scan_phase = SCAN_HUNT;
                     log_event(hfr_pkg::EV_FORMAT, 8'd0);
                  end else begin
                     bytes_left = len_acc;
                     digest_acc = '0;
                     scan_pos = 0;
                     scan_phase = (len_acc != 0) ? SCAN_PAYLOAD : SCAN_DIGEST;
                     log_event(hfr_pkg::EV_HEADER, 8'd0);
                  end
               end else begin
                  if (scan_pos == 0) cmd_seen = b;
                  else if (scan_pos == 1 || scan_pos == hfr_pkg::HEX_DIGITS + 2) begin
                     if (b != hfr_pkg::CHAR_COMMA) header_good = 1'b0;
                  end else if (scan_pos <= hfr_pkg::HEX_DIGITS + 1)
                     arg_acc = shift_hex(arg_acc, b);
                  else len_acc = shift_hex(len_acc, b);
                  scan_pos = (scan_pos + 1) & 31;
               end
            end
         end
         SCAN_PAYLOAD: begin
            crc_acc = crc32c_byte(crc_acc, b);
            if (!raw_mode && scan_pos == 0) begin
               v = hex_nibble(b);
               high_nibble = (v < 0) ? 4'hF : v[3:0];
               scan_pos = 1;
            end else begin
               if (raw_mode) data = b;
               else begin
                  v = hex_nibble(b);
                  low = (v < 0) ? 8'hFF : {4'd0, v[3:0]};
                  data = {high_nibble, 4'd0} + low;
                  scan_pos = 0;
               end
               bytes_left = bytes_left - 1;
               if (bytes_left == 0) begin
                  scan_phase = SCAN_DIGEST;
                  scan_pos = 0;
                  digest_acc = '0;
               end
               log_event(hfr_pkg::EV_PAYLOAD, data);
            end
         end
         SCAN_DIGEST: begin
            if (scan_pos + 1 < hfr_pkg::DIGEST_DIGITS && term) begin
               scan_phase = SCAN_HUNT;
               log_event(hfr_pkg::EV_CRC, 8'd0);
            end else begin
               digest_acc = shift_hex(digest_acc, b);
               scan_pos = scan_pos + 1;
               if (scan_pos >= hfr_pkg::DIGEST_DIGITS) begin
                  scan_phase = SCAN_HUNT;
                  log_event((digest_acc == ~crc_acc) ? hfr_pkg::EV_OK : hfr_pkg::EV_CRC,
                            8'd0);
               end
            end
         end
         default: begin
            if (b == scan_open_char) begin
               clear_decoder();
               scan_phase = SCAN_HEADER;
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
         tx_calm = 0;
      end else if (!req_valid || !req_stall) begin
         if (tx_calm != 0) tx_calm--;
         else if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 60);
         if (tx_gap != 0 || byte_backlog.size() == 0) begin
            if (tx_gap != 0) tx_gap--;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_rx_byte <= byte_backlog.pop_front();
            tx_gap = pick_gap(tx_calm != 0);
         end
      end
   end

   // ------------------------------------------------------------------
   // event monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      frame_event_type want;
      if (reset) begin
         clear_decoder();
         scan_open_char = 8'd0;
         events_due.delete();
         rsp_stall <= 1'b0;
         rx_hold = 0;
         rx_calm = 0;
      end else begin
         if (csr_wr_en) scan_open_char = csr_wr_data;
         if (req_valid && !req_stall) advance_decoder(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (events_due.size() == 0) begin
               report_mismatch($sformatf("unexpected event kind %0d", rsp_event_kind));
            end else begin
               want = events_due.pop_front();
               if (rsp_event_kind !== want.kind)
                  report_mismatch($sformatf("event_kind %0d, want %0d",
                                            rsp_event_kind, want.kind));
               if (rsp_command_char !== want.cmd)
                  report_mismatch($sformatf("command_char %02h, want %02h",
                                            rsp_command_char, want.cmd));
               if (rsp_argument !== want.arg)
                  report_mismatch($sformatf("argument %08h, want %08h",
                                            rsp_argument, want.arg));
               if (rsp_payload_length !== want.len)
                  report_mismatch($sformatf("payload_length %08h, want %08h",
                                            rsp_payload_length, want.len));
               if (rsp_binary_payload !== want.raw)
                  report_mismatch($sformatf("binary_payload %0b, want %0b",
                                            rsp_binary_payload, want.raw));
               if (rsp_payload_byte !== want.data)
                  report_mismatch($sformatf("payload_byte %02h, want %02h",
                                            rsp_payload_byte, want.data));
            end
         end
         if (rx_calm != 0) rx_calm--;
         else if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 60);
         if (rx_hold != 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rx_hold = pick_gap(rx_calm != 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // frame builder
   // ------------------------------------------------------------------
   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 10) return hfr_pkg::CHAR_0 + n;
      return (upper ? hfr_pkg::CHAR_UA : hfr_pkg::CHAR_LA) + (n - 4'd10);
   endfunction

   function automatic logic [7:0] stray_char(input logic [7:0] avoid);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == avoid || c == hfr_pkg::CHAR_HASH || c == hfr_pkg::CHAR_PERCENT);
      return c;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      if ($urandom_range(0, 5) == 0) return 8'h00;
      do c = 8'($urandom_range(0, 255));
      while (hex_nibble(c) >= 0 || c == hfr_pkg::CHAR_HASH || c == hfr_pkg::CHAR_PERCENT);
      return c;
   endfunction

   function automatic logic [7:0] term_char();
      return $urandom_range(0, 1) ? hfr_pkg::CHAR_HASH : hfr_pkg::CHAR_PERCENT;
   endfunction

   task automatic send_frame(input logic [7:0] cmd, input logic [31:0] arg,
                             input logic [31:0] len, input bit raw,
                             input frame_flaw_type flaw);
      logic [7:0]  body[$];
      logic [7:0]  digest[$];
      logic [31:0] crc, sum;
      logic [7:0]  b;
      logic [3:0]  nudge;
      int          k, spot;
      bit          header_only;
      body.push_back(cmd);
      body.push_back(hfr_pkg::CHAR_COMMA);
      for (k = hfr_pkg::HEX_DIGITS - 1; k >= 0; k--)
         body.push_back(hex_char(arg[4*k +: 4], $urandom_range(0, 1)));
      body.push_back(hfr_pkg::CHAR_COMMA);
      for (k = hfr_pkg::HEX_DIGITS - 1; k >= 0; k--)
         body.push_back(hex_char(len[4*k +: 4], $urandom_range(0, 1)));
      body.push_back(raw ? hfr_pkg::CHAR_PERCENT : hfr_pkg::CHAR_HASH);
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 7) == 0) b = frame_open_char;
         else b = 8'($urandom_range(0, 255));
         if (raw) body.push_back(b);
         else begin
            body.push_back(hex_char(b[7:4], $urandom_range(0, 1)));
            body.push_back(hex_char(b[3:0], $urandom_range(0, 1)));
         end
      end
      header_only = 1'b0;
      case (flaw)
         FLAW_COMMA: begin
            body[$urandom_range(0, 1) ? 1 : hfr_pkg::HEX_DIGITS + 2] =
               stray_char(hfr_pkg::CHAR_COMMA);
            header_only = 1'b1;
         end
         FLAW_DELIM: begin
            body[hfr_pkg::LAST_POS] = stray_char(hfr_pkg::CHAR_HASH);
            header_only = 1'b1;
         end
         FLAW_LEN_DIGIT: begin
            body[$urandom_range(hfr_pkg::HEX_DIGITS + 3, 2 * hfr_pkg::HEX_DIGITS + 2)] =
               non_hex_char();
            body[hfr_pkg::LAST_POS] = stray_char(hfr_pkg::CHAR_HASH);
            header_only = 1'b1;
         end
         FLAW_HEADER_CUT: begin
            spot = $urandom_range(0, hfr_pkg::LAST_POS - 1);
            while (body.size() > spot) body.delete(body.size() - 1);
            body.push_back(term_char());
         end
         FLAW_ARG_DIGIT: body[$urandom_range(2, hfr_pkg::HEX_DIGITS + 1)] = non_hex_char();
         FLAW_PAYLOAD_DIGIT: begin
            if (!raw && len != 0)
               body[hfr_pkg::LAST_POS + 1 + $urandom_range(0, 2 * len - 1)] = non_hex_char();
         end
         default: ;
      endcase
      // drop whatever follows a rejected header so it cannot open a frame
      if (header_only)
         while (body.size() > hfr_pkg::LAST_POS + 1) body.delete(body.size() - 1);
      if (!header_only && flaw != FLAW_HEADER_CUT) begin
         crc = 32'hFFFF_FFFF;
         foreach (body[i]) crc = crc32c_byte(crc, body[i]);
         sum = ~crc;
         for (k = hfr_pkg::DIGEST_DIGITS - 1; k >= 0; k--)
            digest.push_back(hex_char(sum[4*k +: 4], $urandom_range(0, 1)));
         case (flaw)
            FLAW_CRC: begin
               spot = $urandom_range(0, hfr_pkg::DIGEST_DIGITS - 1);
               nudge = 4'($urandom_range(1, 15));
               digest[spot] =
                  hex_char(sum[4*(hfr_pkg::DIGEST_DIGITS - 1 - spot) +: 4] ^ nudge, 0);
            end
            FLAW_DIGEST_DIGIT:
               digest[$urandom_range(0, hfr_pkg::DIGEST_DIGITS - 1)] = non_hex_char();
            FLAW_DIGEST_CUT: begin
               spot = $urandom_range(0, hfr_pkg::DIGEST_DIGITS - 2);
               while (digest.size() > spot) digest.delete(digest.size() - 1);
               digest.push_back(term_char());
            end
            FLAW_DIGEST_TERM: digest[hfr_pkg::DIGEST_DIGITS - 1] = term_char();
            default: ;
         endcase
      end
      byte_backlog.push_back(frame_open_char);
      foreach (body[i]) byte_backlog.push_back(body[i]);
      foreach (digest[i]) byte_backlog.push_back(digest[i]);
   endtask

   task automatic send_noise();
      int         n;
      logic [7:0] c;
      n = $urandom_range(1, 4);
      repeat (n) begin
         do c = 8'($urandom_range(0, 255));
         while (c == frame_open_char);
         byte_backlog.push_back(c);
      end
   endtask

   task automatic wait_idle();
      while (byte_backlog.size() != 0 || req_valid || events_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_start_char(input logic [7:0] ch);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= ch;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_open_char = ch;
   endtask

   task automatic run_random(input int quota);
      int             used, queued, r;
      frame_flaw_type flaw;
      logic [7:0]     cmd;
      logic [31:0]    arg, len;
      used = 0;
      while (used < quota) begin
         while (byte_backlog.size() > 64) @(posedge clock);
         queued = byte_backlog.size();
         if ($urandom_range(0, 2) == 0) send_noise();
         flaw = ($urandom_range(0, 99) < 55) ? FLAW_NONE
                : frame_flaw_type'($urandom_range(FLAW_COMMA, FLAW_DIGEST_TERM));
         do cmd = 8'($urandom_range(0, 255));
         while (cmd == hfr_pkg::CHAR_HASH || cmd == hfr_pkg::CHAR_PERCENT);
         r = $urandom_range(0, 3);
         arg = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
         r = $urandom_range(0, 99);
         len = (r < 20) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(4, 16);
         send_frame(cmd, arg, len, $urandom_range(0, 2) == 0, flaw);
         used += byte_backlog.size() - queued;
         // now and then hold the sender until every pending event is back
         if ($urandom_range(0, 9) == 0) wait_idle();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      byte_backlog.push_back(frame_open_char);
      byte_backlog.push_back(hfr_pkg::CHAR_HASH);
      send_frame(8'h6D, 32'hFFFF_FFFF, 32'd0, 1'b1, FLAW_NONE);
      send_frame(8'hFF, 32'h0000_0000, 32'd2, 1'b0, FLAW_PAYLOAD_DIGIT);
      send_frame(8'h00, 32'h1234_ABCD, 32'd1, 1'b1, FLAW_DELIM);
      send_frame(8'h47, 32'h5A5A_A5A5, 32'd0, 1'b0, FLAW_DIGEST_CUT);
      run_random(PHASE_BYTES);

      write_start_char(8'h3A);
      run_random(PHASE_BYTES);
      write_start_char(8'hFF);
      run_random(PHASE_BYTES);
      write_start_char(8'h00);
      run_random(PHASE_BYTES);
      write_start_char(8'($urandom_range(0, 255)));
      run_random(PHASE_BYTES);

      wait_idle();
      if (mismatch_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
